### hw/rtl/gtw_pkg.sv
// gtw_pkg: shared types and constants of the ghost tile walker
// no dependencies
`timescale 1ns / 1ps
package gtw_pkg;
  localparam logic [2:0] ST_STARTED = 3'd0;
  localparam logic [2:0] ST_STORED = 3'd1;
  localparam logic [2:0] ST_TILE_DONE = 3'd2;
  localparam logic [2:0] ST_VOL_DONE = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic [2:0] REG_VOL_W = 3'd0;
  localparam logic [2:0] REG_VOL_H = 3'd1;
  localparam logic [2:0] REG_VOL_D = 3'd2;
  localparam logic [2:0] REG_TILE_W = 3'd3;
  localparam logic [2:0] REG_TILE_H = 3'd4;
  localparam logic [2:0] REG_TILE_D = 3'd5;
  localparam logic [2:0] REG_GHOST = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [15:0] voxel;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] fetch_x;
    logic [11:0] fetch_y;
    logic [11:0] fetch_z;
    logic [24:0] store_index;
    logic [11:0] tile_x;
    logic [11:0] tile_y;
    logic [11:0] tile_z;
    logic [15:0] tile_min;
    logic [15:0] tile_max;
    logic [23:0] tile_mean;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [12:0] data;
  } cfg_word_t;

  // classified command between front and back
  typedef struct packed {
    logic        start;
    logic [15:0] voxel;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_FIN
  } bk_state_t;
endpackage

### hw/rtl/gtw_if.sv
// gtw_if: valid/ready channel carrying one payload word
// depends on gtw_pkg for payload types
`timescale 1ns / 1ps
interface gtw_in_if;
  logic valid;
  logic ready;
  gtw_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtw_out_if;
  logic valid;
  logic ready;
  gtw_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtw_cfg_if;
  logic valid;
  logic ready;
  gtw_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/gtw_front.sv
// gtw_front: accepts input words and queues classified commands
// depends on gtw_pkg
`timescale 1ns / 1ps
module gtw_front (
  input  logic             clk,
  input  logic             rst,
  gtw_in_if.sink           in_ch,
  output gtw_pkg::cmd_t    cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);
  gtw_pkg::cmd_t q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].start <= ~in_ch.data.mode;
      q[wr_ptr].voxel <= in_ch.data.voxel;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad count");
endmodule

### hw/rtl/gtw_divider.sv
// gtw_divider: restoring signed divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps
module gtw_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] q;
  logic [25:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [25:0] trial;

  assign trial = {rem[24:0], q[47]} - {1'b0, divisor};
  assign quotient = neg ? -q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd48;
        neg <= dividend[47];
        q <= dividend[47] ? -dividend : dividend;
        rem <= '0;
      end else if (busy) begin
        if (!trial[25]) begin
          rem <= trial;
          q <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[24:0], q[47]};
          q <= {q[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hw/rtl/gtw_back.sv
// gtw_back: walks tiles, tracks core stats and builds result words
// depends on gtw_pkg, gtw_divider
`timescale 1ns / 1ps
module gtw_back #(
  parameter int MAX_DIM = 4096,
  parameter int MAX_TILE = 256,
  parameter int MAX_GHOST = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  gtw_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [12:0]        vol_w,
  input  logic [12:0]        vol_h,
  input  logic [12:0]        vol_d,
  input  logic [8:0]         til_w,
  input  logic [8:0]         til_h,
  input  logic [8:0]         til_d,
  input  logic [4:0]         ghost,
  gtw_out_if.source          out_ch
);
  localparam logic [17:0] MD = 18'(MAX_DIM);
  localparam logic [17:0] MT = 18'(MAX_TILE);
  localparam logic [17:0] MG = 18'(MAX_GHOST);

  gtw_pkg::bk_state_t state, state_next;
  logic        walking;
  logic [17:0] vn [3];
  logic [17:0] tn [3];
  logic [17:0] gw;
  logic [17:0] tidx [3];
  logic [17:0] tbase [3];
  logic [17:0] sc [3];
  logic [17:0] clen [3];
  logic [24:0] store_counter;
  logic signed [15:0] rmin, rmax;
  logic signed [39:0] rsum;
  logic [24:0] ccount;
  logic [23:0] mean_hold;
  gtw_pkg::out_word_t word;
  logic        div_start, div_done;
  logic [47:0] div_q;
  logic signed [39:0] div_sum;
  logic [24:0] div_cnt;
  logic        can_emit;

  function automatic logic [17:0] sat13(logic [12:0] v, logic [17:0] lo,
                                        logic [17:0] hi);
    logic [17:0] w;
    w = 18'(v);
    if (w < lo) return lo;
    if (w > hi) return hi;
    return w;
  endfunction

  function automatic logic [11:0] clampc(logic [17:0] base, logic [17:0] g,
                                         logic [17:0] s, logic [17:0] n);
    logic signed [19:0] c;
    c = $signed({2'b0, base}) - $signed({2'b0, g}) + $signed({2'b0, s});
    if (c < 0) return '0;
    if (c > $signed({2'b0, n}) - 20'sd1) return 12'(n - 18'd1);
    return 12'(c);
  endfunction

  logic [17:0] lim [3];
  logic [17:0] sz [3];
  logic        core, sx_wrap, sy_wrap, sz_end;
  logic        tx_wrap, ty_wrap, tz_end;
  logic [17:0] ntb [3];
  logic [17:0] nti [3];
  logic signed [15:0] vox;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a] = tbase[a] + tn[a];
      clen[a] = (lim[a] > vn[a]) ? vn[a] - tbase[a] : tn[a];
      sz[a] = clen[a] + {gw[16:0], 1'b0};
    end
    vox = $signed(cmd.voxel);
    core = 1'b1;
    for (int a = 0; a < 3; a++)
      core = core && (sc[a] >= gw) && (sc[a] < gw + clen[a]);
    div_sum = rsum + (core ? 40'(vox) : 40'sd0);
    div_cnt = ccount + {24'd0, core};
    sx_wrap = (sc[0] + 18'd1 >= sz[0]);
    sy_wrap = sx_wrap && (sc[1] + 18'd1 >= sz[1]);
    sz_end = sy_wrap && (sc[2] + 18'd1 >= sz[2]);
    for (int a = 0; a < 3; a++) ntb[a] = tbase[a] + tn[a];
    tx_wrap = (ntb[0] >= vn[0]);
    ty_wrap = tx_wrap && (ntb[1] >= vn[1]);
    tz_end = ty_wrap && (ntb[2] >= vn[2]);
    nti[0] = tx_wrap ? '0 : tidx[0] + 18'd1;
    nti[1] = tx_wrap ? (ty_wrap ? '0 : tidx[1] + 18'd1) : tidx[1];
    nti[2] = ty_wrap ? tidx[2] + 18'd1 : tidx[2];
  end

  assign can_emit = !out_ch.valid || out_ch.ready;
  assign div_start = (state == gtw_pkg::BK_RUN) && cmd_valid && can_emit &&
                     !cmd.start && walking && sz_end && (div_cnt != 25'd0);

  gtw_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({div_sum, 8'd0}),
    .divisor(div_cnt),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    unique case (state)
      gtw_pkg::BK_RUN: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = !div_start;
          if (div_start) state_next = gtw_pkg::BK_DIV;
        end
      end
      gtw_pkg::BK_DIV: if (div_done) state_next = gtw_pkg::BK_FIN;
      gtw_pkg::BK_FIN: if (can_emit) begin
        cmd_pop = 1'b1;
        state_next = gtw_pkg::BK_RUN;
      end
      default: state_next = gtw_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gtw_pkg::BK_RUN;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == gtw_pkg::BK_DIV && div_done) mean_hold <= div_q[23:0];
  end

  // result word for the command at the head of the queue
  always_comb begin
    word = '0;
    if (cmd.start) begin
      word.status = gtw_pkg::ST_STARTED;
      word.fetch_x = clampc(18'd0, sat13({8'b0, ghost}, 18'd0, MG),
                            18'd0, sat13(vol_w, 18'd1, MD));
      word.fetch_y = clampc(18'd0, sat13({8'b0, ghost}, 18'd0, MG),
                            18'd0, sat13(vol_h, 18'd1, MD));
      word.fetch_z = clampc(18'd0, sat13({8'b0, ghost}, 18'd0, MG),
                            18'd0, sat13(vol_d, 18'd1, MD));
    end else if (!walking) begin
      word.status = gtw_pkg::ST_IGNORED;
    end else if (!sz_end) begin
      word.status = gtw_pkg::ST_STORED;
      word.store_index = store_counter;
      word.tile_x = tidx[0][11:0];
      word.tile_y = tidx[1][11:0];
      word.tile_z = tidx[2][11:0];
      word.fetch_x = clampc(tbase[0], gw, sx_wrap ? '0 : sc[0] + 18'd1, vn[0]);
      word.fetch_y = clampc(tbase[1], gw,
        sx_wrap ? (sy_wrap ? '0 : sc[1] + 18'd1) : sc[1], vn[1]);
      word.fetch_z = clampc(tbase[2], gw, sy_wrap ? sc[2] + 18'd1 : sc[2], vn[2]);
    end else begin
      word.status = tz_end ? gtw_pkg::ST_VOL_DONE : gtw_pkg::ST_TILE_DONE;
      word.store_index = store_counter;
      word.tile_x = tidx[0][11:0];
      word.tile_y = tidx[1][11:0];
      word.tile_z = tidx[2][11:0];
      if (div_cnt != 25'd0) begin
        word.tile_min = (core && vox < rmin) ? vox : rmin;
        word.tile_max = (core && vox > rmax) ? vox : rmax;
        word.tile_mean = mean_hold;
      end
      if (!tz_end) begin
        word.fetch_x = clampc(tx_wrap ? '0 : ntb[0], gw, '0, vn[0]);
        word.fetch_y = clampc(tx_wrap ? (ty_wrap ? '0 : ntb[1]) : tbase[1],
                              gw, '0, vn[1]);
        word.fetch_z = clampc(ty_wrap ? ntb[2] : tbase[2], gw, '0, vn[2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      walking <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        vn[a] <= 18'd1; tn[a] <= 18'd1; tidx[a] <= '0; tbase[a] <= '0; sc[a] <= '0;
      end
      gw <= '0;
      store_counter <= '0;
      rmin <= 16'sh7fff; rmax <= 16'sh8000; rsum <= '0; ccount <= '0;
    end else begin
      if (cmd_pop) begin
        out_ch.valid <= 1'b1;
        out_ch.data <= word;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cmd_pop) begin
        if (cmd.start) begin
          vn[0] <= sat13(vol_w, 18'd1, MD);
          vn[1] <= sat13(vol_h, 18'd1, MD);
          vn[2] <= sat13(vol_d, 18'd1, MD);
          tn[0] <= sat13({4'b0, til_w}, 18'd1, MT);
          tn[1] <= sat13({4'b0, til_h}, 18'd1, MT);
          tn[2] <= sat13({4'b0, til_d}, 18'd1, MT);
          gw <= sat13({8'b0, ghost}, 18'd0, MG);
          walking <= 1'b1;
          for (int a = 0; a < 3; a++) begin
            tidx[a] <= '0; tbase[a] <= '0; sc[a] <= '0;
          end
          store_counter <= '0;
          rmin <= 16'sh7fff; rmax <= 16'sh8000; rsum <= '0; ccount <= '0;
        end else if (!walking) begin
        end else if (!sz_end) begin
          if (core) begin
            if (vox < rmin) rmin <= vox;
            if (vox > rmax) rmax <= vox;
            rsum <= rsum + 40'(vox);
            ccount <= ccount + 25'd1;
          end
          store_counter <= store_counter + 25'd1;
          sc[0] <= sx_wrap ? '0 : sc[0] + 18'd1;
          if (sx_wrap) sc[1] <= sy_wrap ? '0 : sc[1] + 18'd1;
          if (sy_wrap) sc[2] <= sc[2] + 18'd1;
        end else begin
          for (int a = 0; a < 3; a++) sc[a] <= '0;
          store_counter <= '0;
          rmin <= 16'sh7fff; rmax <= 16'sh8000; rsum <= '0; ccount <= '0;
          if (tz_end) begin
            walking <= 1'b0;
            for (int a = 0; a < 3; a++) begin tidx[a] <= '0; tbase[a] <= '0; end
          end else begin
            tidx[0] <= nti[0];
            tbase[0] <= tx_wrap ? '0 : ntb[0];
            if (tx_wrap) begin
              tidx[1] <= nti[1];
              tbase[1] <= ty_wrap ? '0 : ntb[1];
            end
            if (ty_wrap) begin
              tidx[2] <= nti[2];
              tbase[2] <= ntb[2];
            end
          end
        end
      end
    end
  end

  a_pop_when_room: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> can_emit) else $error("pop without output room");
  a_div_only_run: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == gtw_pkg::BK_RUN) else $error("divider start out of run");
  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    state == gtw_pkg::BK_FIN |-> $past(state) != gtw_pkg::BK_RUN)
    else $error("finish without divide");
endmodule

### hw/rtl/ghost_tile_walker_with_stats.sv
// ghost_tile_walker_with_stats: walks a volume in ghost-bordered tiles and reports
// per-tile core min, max and mean. Each accepted word yields one result word;
// a voxel word is answered from the run state; a tile-end word with core voxels
// waits while the serial mean divider produces one quotient bit a cycle.
// depends on gtw_pkg, gtw_if, gtw_front, gtw_divider, gtw_back
`timescale 1ns / 1ps
module ghost_tile_walker_with_stats #(
  parameter int MAX_DIM = 4096,
  parameter int MAX_TILE = 256,
  parameter int MAX_GHOST = 16
) (
  input logic       clk,
  input logic       rst,
  gtw_in_if.sink    in_ch,
  gtw_out_if.source out_ch,
  gtw_cfg_if.sink   cfg
);
  logic [12:0] vol_w, vol_h, vol_d;
  logic [8:0]  til_w, til_h, til_d;
  logic [4:0]  ghost;
  gtw_pkg::cmd_t cmd;
  logic cmd_valid, cmd_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_w <= 13'd1; vol_h <= 13'd1; vol_d <= 13'd1;
      til_w <= 9'd1; til_h <= 9'd1; til_d <= 9'd1;
      ghost <= 5'd0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        gtw_pkg::REG_VOL_W: vol_w <= cfg.data.data;
        gtw_pkg::REG_VOL_H: vol_h <= cfg.data.data;
        gtw_pkg::REG_VOL_D: vol_d <= cfg.data.data;
        gtw_pkg::REG_TILE_W: til_w <= cfg.data.data[8:0];
        gtw_pkg::REG_TILE_H: til_h <= cfg.data.data[8:0];
        gtw_pkg::REG_TILE_D: til_d <= cfg.data.data[8:0];
        gtw_pkg::REG_GHOST: ghost <= cfg.data.data[4:0];
        default: ;
      endcase
    end
  end

  gtw_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  gtw_back #(.MAX_DIM(MAX_DIM), .MAX_TILE(MAX_TILE), .MAX_GHOST(MAX_GHOST)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
    .vol_w(vol_w), .vol_h(vol_h), .vol_d(vol_d),
    .til_w(til_w), .til_h(til_h), .til_d(til_d), .ghost(ghost),
    .out_ch(out_ch)
  );
endmodule
